// ===== sv/ole_pkg.sv =====
// Shared types and constants for the ordered list engine.
// Depends on nothing; imported by every module of the block.
package ole_pkg;

  // Default sizes handed down by the top level
  localparam int unsigned DEPTH_DEF       = 16;
  localparam int unsigned VALUE_WIDTH_DEF = 32;

  // Fixed field widths on the ports
  localparam int unsigned OP_W          = 2;
  localparam int unsigned ITEM_W        = 32;
  localparam int unsigned STATUS_W      = 2;
  localparam int unsigned COUNT_FIELD_W = 5;
  localparam int unsigned OUT_DATA_W    = 8;

  // Request kinds
  typedef enum logic [OP_W-1:0] {
    OP_PUSH_FRONT = 2'd0,
    OP_PUSH_BACK  = 2'd1,
    OP_SEARCH     = 2'd2,
    OP_REMOVE     = 2'd3
  } op_e;

  // Response status
  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 2'd0,
    ST_ABSENT = 2'd1,
    ST_FULL   = 2'd2
  } status_e;

  // Controller states
  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic load;  // capture request, compare all cells
    logic exec;  // apply update, load response register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_free;  // response register can take a new response
  } sts_t;

endpackage

// ===== sv/ole_ctrl.sv =====
// Request sequencer of the ordered list engine: capture, then execute.
// Depends on ole_pkg for the state, command and status types.
module ole_ctrl
  import ole_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic req_valid_i,
  input  sts_t sts_i,
  output logic req_ready_o,
  output cmd_t cmd_o
);

  state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (req_valid_i) state_d = S_EXEC;
      S_EXEC: if (sts_i.out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    req_ready_o = 1'b0;
    cmd_o       = '0;
    unique case (state_q)
      S_IDLE: begin
        req_ready_o = 1'b1;
        cmd_o.load  = req_valid_i;
      end
      S_EXEC: begin
        cmd_o.exec = sts_i.out_free;
      end
      default: ;
    endcase
  end

endmodule

// ===== sv/ole_dp.sv =====
// Datapath of the ordered list engine: cell row with per-cell compare,
// shift network, count register and response register. Depends on ole_pkg.
module ole_dp
  import ole_pkg::*;
#(
  parameter int unsigned DEPTH       = DEPTH_DEF,
  parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF,
  localparam int unsigned CW         = $clog2(DEPTH + 1)
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  cmd_t                     cmd_i,
  output sts_t                     sts_o,
  input  logic [OP_W-1:0]          req_op_i,
  input  logic [ITEM_W-1:0]        req_value_i,
  output logic                     rsp_valid_o,
  input  logic                     rsp_ready_i,
  output logic [STATUS_W-1:0]      rsp_status_o,
  output logic [COUNT_FIELD_W-1:0] rsp_count_o,
  output logic [CW-1:0]            count_o
);

  logic [VALUE_WIDTH-1:0] val_in;
  op_e                    op_q;
  logic [VALUE_WIDTH-1:0] val_q;
  logic [DEPTH-1:0]       match_q;
  logic [DEPTH-1:0]       hit_upto;
  logic [VALUE_WIDTH-1:0] cells_q [DEPTH];
  logic [VALUE_WIDTH-1:0] cells_d [DEPTH];
  logic [CW-1:0]          count_q, count_d;
  logic                   full, hit;
  status_e                status_d;
  logic                   out_valid_q;
  status_e                out_status_q;
  logic [COUNT_FIELD_W-1:0] out_count_q;

  // Sign-extend or truncate the 32-bit request value to the stored width
  if (VALUE_WIDTH > ITEM_W) begin : g_ext
    assign val_in = {{(VALUE_WIDTH - ITEM_W){req_value_i[ITEM_W-1]}}, req_value_i};
  end else begin : g_trunc
    assign val_in = req_value_i[VALUE_WIDTH-1:0];
  end

  // Capture request and per-cell match bits, valid cells only
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= op_e'(req_op_i);
      val_q <= val_in;
      for (int i = 0; i < DEPTH; i++) begin
        match_q[i] <= (cells_q[i] == val_in) && (CW'(i) < count_q);
      end
    end
  end

  assign full = (count_q == CW'(DEPTH));
  assign hit  = |match_q;

  // Per cell: next value for each request kind
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [VALUE_WIDTH-1:0] prev_w, next_w;

    // Set when the first match lies at or below this cell
    assign hit_upto[g] = |match_q[g:0];

    if (g == 0) begin : g_first
      assign prev_w = val_q;
    end else begin : g_mid
      assign prev_w = cells_q[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign next_w = cells_q[g];
    end else begin : g_inner
      assign next_w = cells_q[g+1];
    end

    always_comb begin
      cells_d[g] = cells_q[g];
      unique case (op_q)
        OP_PUSH_FRONT: if (!full) cells_d[g] = prev_w;
        OP_PUSH_BACK:  if (!full && (count_q == CW'(g))) cells_d[g] = val_q;
        OP_SEARCH:     cells_d[g] = cells_q[g];
        OP_REMOVE:     if (hit_upto[g]) cells_d[g] = next_w;
        default:       cells_d[g] = cells_q[g];
      endcase
    end
  end

  // Cell storage, no reset: only entries below the count are read
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      cells_q <= cells_d;
    end
  end

  // Count and status for the executing request
  always_comb begin
    count_d  = count_q;
    status_d = ST_OK;
    unique case (op_q)
      OP_PUSH_FRONT, OP_PUSH_BACK: begin
        if (full) begin
          status_d = ST_FULL;
        end else begin
          count_d = count_q + CW'(1);
        end
      end
      OP_SEARCH: begin
        if (!hit) status_d = ST_ABSENT;
      end
      OP_REMOVE: begin
        if (hit) begin
          count_d = count_q - CW'(1);
        end else begin
          status_d = ST_ABSENT;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.exec) begin
      count_q <= count_d;
    end
  end

  // Response register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.exec) begin
      out_valid_q <= 1'b1;
    end else if (rsp_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      out_status_q <= status_d;
      out_count_q  <= COUNT_FIELD_W'(count_d);
    end
  end

  assign sts_o.out_free = !out_valid_q || rsp_ready_i;
  assign rsp_valid_o    = out_valid_q;
  assign rsp_status_o   = out_status_q;
  assign rsp_count_o    = out_count_q;
  assign count_o        = count_q;

endmodule

// ===== sv/ordered_list_engine.sv =====
// Ordered list engine: bounded double-ended list with search and delete.
// Instantiates ole_ctrl and ole_dp; depends on ole_pkg.
//
// Usage:
//   Requests arrive on the s_axis group: tuser carries the request kind
//   (push front, push back, search, remove first match), tdata the 32-bit
//   signed value. Each request yields exactly one response on m_axis:
//   tuser carries the status (ok/found, absent, full), tdata the number of
//   entries held after the request.
//   A request is handled in a capture step, which compares the value
//   against every cell in parallel, then an execute step, which shifts
//   the cell row and updates the count. A new request is taken only
//   after the previous one has executed.
//   s_axis_tready is high while the sequencer waits for a request, also
//   while an earlier response is still held in the output register.
//   If the receiver stalls, the finished request waits in its execute
//   step until the output register frees up; no request is lost.
//   Reset clears the count (empty list) and drops any pending response;
//   cell contents are not cleared.
module ordered_list_engine
  import ole_pkg::*;
#(
  parameter int unsigned DEPTH       = DEPTH_DEF,
  parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [ITEM_W-1:0]     s_axis_tdata,   // [31:0] item_value
  input  logic [OP_W-1:0]       s_axis_tuser,   // [1:0] op
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,   // [4:0] entry_count, [7:5] zero
  output logic [STATUS_W-1:0]   m_axis_tuser    // [1:0] status
);

  localparam int unsigned CW = $clog2(DEPTH + 1);

  cmd_t                     cmd;
  sts_t                     sts;
  logic [COUNT_FIELD_W-1:0] rsp_count;
  logic [CW-1:0]            count;

  ole_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid),
    .sts_i       (sts),
    .req_ready_o (s_axis_tready),
    .cmd_o       (cmd)
  );

  ole_dp #(
    .DEPTH       (DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .req_op_i     (s_axis_tuser),
    .req_value_i  (s_axis_tdata),
    .rsp_valid_o  (m_axis_tvalid),
    .rsp_ready_i  (m_axis_tready),
    .rsp_status_o (m_axis_tuser),
    .rsp_count_o  (rsp_count),
    .count_o      (count)
  );

  assign m_axis_tdata = {{(OUT_DATA_W - COUNT_FIELD_W){1'b0}}, rsp_count};

  // Count never exceeds capacity
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count <= CW'(DEPTH))
    else $error("entry count above capacity");

  // An accepted request blocks the next one for its execute step
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("request accepted while another executes");

  // Execute always leaves a response pending
  a_exec_rsp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.exec |=> m_axis_tvalid)
    else $error("execute without response");

  // A refused insert is only reported with a full list
  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser == ST_FULL)) |-> (count == CW'(DEPTH)))
    else $error("full status with room left");

endmodule

// ===== tb/ole_list_checker.sv =====
// Response checker for the ordered list engine testbench.
// Keeps a mirror of the list, predicts each answer and compares; depends on ole_pkg.
module ole_list_checker
  import ole_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  req_valid_i,
  input  logic                  req_ready_i,
  input  logic [ITEM_W-1:0]     req_data_i,
  input  logic [OP_W-1:0]       req_user_i,
  input  logic                  rsp_valid_i,
  input  logic                  rsp_ready_i,
  input  logic [OUT_DATA_W-1:0] rsp_data_i,
  input  logic [STATUS_W-1:0]   rsp_user_i,
  output int unsigned           fail_count_o,
  output int unsigned           open_answers_o,
  output int unsigned           req_seen_o,
  output int unsigned           full_seen_o,
  output int unsigned           absent_seen_o,
  output int unsigned           peak_count_o
);

  typedef struct packed {
    status_e                  status;
    logic [COUNT_FIELD_W-1:0] count;
  } answer_t;

  // Mirror of the list held by the block
  logic [ITEM_W-1:0] mirror_cells [DEPTH_DEF];
  int                mirror_count;
  answer_t           pending_answers [$];

  int unsigned fails, reqs, fulls, absents, peak;

  initial begin
    fails          = 0;
    reqs           = 0;
    fulls          = 0;
    absents        = 0;
    peak           = 0;
    mirror_count   = 0;
    fail_count_o   = 0;
    open_answers_o = 0;
    req_seen_o     = 0;
    full_seen_o    = 0;
    absent_seen_o  = 0;
    peak_count_o   = 0;
  end

  // Apply one request to the mirror and return the answer it must produce
  function automatic answer_t apply_request(op_e op, logic [ITEM_W-1:0] value);
    answer_t ans;
    int      hit;
    ans.status = ST_OK;
    hit = mirror_count;
    // first match counted from the front
    for (int i = 0; i < DEPTH_DEF; i++)
      if (i < mirror_count && hit == mirror_count && mirror_cells[i] == value) hit = i;
    case (op)
      OP_PUSH_FRONT: begin
        if (mirror_count >= DEPTH_DEF) begin
          ans.status = ST_FULL;
        end else begin
          for (int i = DEPTH_DEF - 1; i > 0; i--)
            if (i <= mirror_count) mirror_cells[i] = mirror_cells[i-1];
          mirror_cells[0] = value;
          mirror_count++;
        end
      end
      OP_PUSH_BACK: begin
        if (mirror_count >= DEPTH_DEF) begin
          ans.status = ST_FULL;
        end else begin
          mirror_cells[mirror_count] = value;
          mirror_count++;
        end
      end
      OP_SEARCH: begin
        if (hit >= mirror_count) ans.status = ST_ABSENT;
      end
      default: begin
        if (hit >= mirror_count) begin
          ans.status = ST_ABSENT;
        end else begin
          // close the gap behind the removed entry
          for (int i = 0; i < DEPTH_DEF - 1; i++)
            if (i >= hit && i + 1 < mirror_count) mirror_cells[i] = mirror_cells[i+1];
          mirror_count--;
        end
      end
    endcase
    ans.count = mirror_count[COUNT_FIELD_W-1:0];
    return ans;
  endfunction

  task automatic note_error(string msg);
    fails++;
    if (fails <= 10) $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  // Sample both channels at the edge; answers are checked before new requests
  always @(posedge clk_i or negedge rst_ni) begin
    answer_t exp_ans;
    answer_t new_ans;
    if (!rst_ni) begin
      mirror_count = 0;
      pending_answers.delete();
    end else begin
      if (rsp_valid_i && rsp_ready_i) begin
        if (pending_answers.size() == 0) begin
          note_error($sformatf("response with none outstanding: status %0d data 0x%02h",
                               rsp_user_i, rsp_data_i));
        end else begin
          exp_ans = pending_answers.pop_front();
          if (rsp_user_i !== exp_ans.status)
            note_error($sformatf("status exp %0d (%s) got %0d",
                                 exp_ans.status, exp_ans.status.name(), rsp_user_i));
          if (rsp_data_i[COUNT_FIELD_W-1:0] !== exp_ans.count)
            note_error($sformatf("entry count exp %0d got %0d",
                                 exp_ans.count, rsp_data_i[COUNT_FIELD_W-1:0]));
          if (rsp_data_i[OUT_DATA_W-1:COUNT_FIELD_W] !== '0)
            note_error($sformatf("tdata pad bits exp 0 got 0x%0h",
                                 rsp_data_i[OUT_DATA_W-1:COUNT_FIELD_W]));
        end
      end
      if (req_valid_i && req_ready_i) begin
        new_ans = apply_request(op_e'(req_user_i), req_data_i);
        pending_answers.push_back(new_ans);
        reqs++;
        if (new_ans.status == ST_FULL) fulls++;
        if (new_ans.status == ST_ABSENT) absents++;
        if (mirror_count > peak) peak = mirror_count;
      end
    end
    fail_count_o   <= fails;
    open_answers_o <= pending_answers.size();
    req_seen_o     <= reqs;
    full_seen_o    <= fulls;
    absent_seen_o  <= absents;
    peak_count_o   <= peak;
  end

endmodule

// ===== tb/ordered_list_engine_tb.sv =====
// Top of the ordered list engine testbench: clock, reset, request and response drivers.
// Instantiates ordered_list_engine and ole_list_checker; depends on ole_pkg.
module ordered_list_engine_tb;
  import ole_pkg::*;

  localparam int unsigned RANDOM_REQS = 1800;
  localparam int unsigned CALM_TAIL   = 200;
  localparam int unsigned HOLD_CYCLES = 80;
  localparam int unsigned QUIET_LIMIT = 3000;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  req_valid = 1'b0;
  logic [ITEM_W-1:0]     req_value = '0;
  logic [OP_W-1:0]       req_op    = OP_SEARCH;
  logic                  rsp_ready = 1'b0;
  logic                  req_ready;
  logic                  rsp_valid;
  logic [OUT_DATA_W-1:0] rsp_data;
  logic [STATUS_W-1:0]   rsp_status;

  bit sender_idles   = 1'b1;
  bit receiver_idles = 1'b1;
  bit hold_request   = 1'b0;

  int unsigned fail_count, open_answers, req_seen, full_seen, absent_seen, peak_count;
  int unsigned quiet_cycles = 0;

  // Value pool: repeats make search and remove hit often
  logic [ITEM_W-1:0] value_pool [8] = '{32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF,
                                        32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0005,
                                        32'h0000_002A, 32'h5A5A_5A5A};

  ordered_list_engine DUT (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_axis_tvalid (req_valid),
    .s_axis_tready (req_ready),
    .s_axis_tdata  (req_value),
    .s_axis_tuser  (req_op),
    .m_axis_tvalid (rsp_valid),
    .m_axis_tready (rsp_ready),
    .m_axis_tdata  (rsp_data),
    .m_axis_tuser  (rsp_status)
  );

  ole_list_checker u_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .req_valid_i    (req_valid),
    .req_ready_i    (req_ready),
    .req_data_i     (req_value),
    .req_user_i     (req_op),
    .rsp_valid_i    (rsp_valid),
    .rsp_ready_i    (rsp_ready),
    .rsp_data_i     (rsp_data),
    .rsp_user_i     (rsp_status),
    .fail_count_o   (fail_count),
    .open_answers_o (open_answers),
    .req_seen_o     (req_seen),
    .full_seen_o    (full_seen),
    .absent_seen_o  (absent_seen),
    .peak_count_o   (peak_count)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Offer one request, with an occasional gap ahead of it, and wait for acceptance
  task automatic send_request(op_e op, logic [ITEM_W-1:0] value);
    if (sender_idles && $urandom_range(0, 3) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    req_valid <= 1'b1;
    req_op    <= op;
    req_value <= value;
    do @(posedge clk); while (!req_ready);
  endtask

  function automatic logic [ITEM_W-1:0] pick_value();
    if ($urandom_range(0, 3) != 0) return value_pool[$urandom_range(0, 7)];
    return $urandom;
  endfunction

  // Response side: random stalls, one long hold-off on request
  initial begin
    wait (rst_n);
    forever begin
      if (hold_request) begin
        rsp_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_request = 1'b0;
      end else if (receiver_idles && $urandom_range(0, 3) == 0) begin
        rsp_ready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end else begin
        rsp_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Watchdog: too long without any request or response moving
  always @(posedge clk) begin
    if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
      quiet_cycles <= 0;
    end else if (rst_n) begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", QUIET_LIMIT);
        $display("simulation failed");
        $finish;
      end
    end
  end

  // Stimulus
  initial begin
    bit          growing;
    int unsigned roll;
    wait (rst_n);
    @(posedge clk);

    // empty list: nothing to find or remove
    send_request(OP_SEARCH, 32'h0000_0000);
    send_request(OP_REMOVE, 32'h0000_0000);
    // fill to capacity from both ends, extremes and a duplicate included
    send_request(OP_PUSH_BACK,  32'h7FFF_FFFF);
    send_request(OP_PUSH_FRONT, 32'h8000_0000);
    send_request(OP_PUSH_BACK,  32'h0000_0000);
    send_request(OP_PUSH_FRONT, 32'hFFFF_FFFF);
    send_request(OP_PUSH_BACK,  32'h0000_0001);
    send_request(OP_PUSH_FRONT, 32'h0000_0007);
    send_request(OP_PUSH_BACK,  32'h0000_0007);
    send_request(OP_PUSH_FRONT, 32'h0000_002A);
    send_request(OP_PUSH_BACK,  32'h5A5A_5A5A);
    send_request(OP_PUSH_FRONT, 32'hA5A5_A5A5);
    send_request(OP_PUSH_BACK,  32'h0000_0100);
    send_request(OP_PUSH_FRONT, 32'h0000_0200);
    send_request(OP_PUSH_BACK,  32'h0000_0300);
    send_request(OP_PUSH_FRONT, 32'h0000_0400);
    send_request(OP_PUSH_BACK,  32'h0000_0500);
    send_request(OP_PUSH_FRONT, 32'h0000_0600);
    // full list refuses inserts at either end
    send_request(OP_PUSH_FRONT, 32'h0000_0009);
    send_request(OP_PUSH_BACK,  32'h0000_0009);
    // hits and misses, first of two duplicates, both ends
    send_request(OP_SEARCH, 32'h8000_0000);
    send_request(OP_SEARCH, 32'h0000_3039);
    send_request(OP_REMOVE, 32'h0000_0007);
    send_request(OP_REMOVE, 32'h0000_0009);
    send_request(OP_REMOVE, 32'h0000_0600);
    send_request(OP_REMOVE, 32'h0000_0500);

    // random part: alternating growth and shrink trends sweep the count
    growing = 1'b1;
    for (int n = 0; n < RANDOM_REQS; n++) begin
      if (n % 64 == 0) growing = $urandom_range(0, 1);
      if (n == 500) hold_request = 1'b1;
      if (n == RANDOM_REQS - CALM_TAIL) begin
        sender_idles   = 1'b0;
        receiver_idles = 1'b0;
      end
      roll = $urandom_range(0, 9);
      if (roll < (growing ? 5 : 3))
        send_request(op_e'($urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK),
                     pick_value());
      else if (roll < (growing ? 7 : 5))
        send_request(OP_SEARCH, pick_value());
      else
        send_request(OP_REMOVE, pick_value());
    end
    req_valid <= 1'b0;

    // drain outstanding answers, then a short settle
    @(posedge clk);
    while (open_answers != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("run covered %0d requests: %0d refused as full, %0d absent, peak count %0d",
             req_seen, full_seen, absent_seen, peak_count);
    $display("%0d mismatches, %0d answers outstanding", fail_count, open_answers);
    if (fail_count == 0 && open_answers == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
